### rtl/tbeq_pkg.sv
// ----------------------------------------------------------------------------
// tbeq_pkg
// Shared types and codes for the touch and button event qualifier.
// ----------------------------------------------------------------------------
package tbeq_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int NUM_SLOTS   = 5;

  localparam int TIME_W  = 32;
  localparam int COORD_W = 16;
  localparam int DEB_W   = 16;
  localparam int IDLE_W  = 31;
  localparam int KIND_W  = 3;
  localparam int BTN_W   = 2;
  localparam int ADDR_W  = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;

  // event kinds
  localparam logic [KIND_W-1:0] EV_TOUCH_DOWN = 3'd0;
  localparam logic [KIND_W-1:0] EV_TOUCH_MOVE = 3'd1;
  localparam logic [KIND_W-1:0] EV_TOUCH_UP   = 3'd2;
  localparam logic [KIND_W-1:0] EV_NAV_UP     = 3'd3;
  localparam logic [KIND_W-1:0] EV_NAV_DOWN   = 3'd4;
  localparam logic [KIND_W-1:0] EV_BACK       = 3'd5;
  localparam logic [KIND_W-1:0] EV_IDLE       = 3'd6;

  // button positions
  localparam int BTN_NAV_UP = 0;
  localparam int BTN_MID    = 1;
  localparam int BTN_NAV_DN = 2;

  // event slots within one item, in emission order
  localparam int SLOT_TOUCH   = 0;
  localparam int SLOT_NAV_UP  = 1;
  localparam int SLOT_BACK    = 2;
  localparam int SLOT_NAV_DN  = 3;
  localparam int SLOT_IDLE    = 4;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_TOUCH_DEB = 2'd0;
  localparam logic [ADDR_W-1:0] REG_BTN_DEB   = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LONG_PRESS = 2'd2;
  localparam logic [ADDR_W-1:0] REG_IDLE_TO   = 2'd3;

  localparam logic [DEB_W-1:0]  TOUCH_DEB_RST  = 16'd150;
  localparam logic [DEB_W-1:0]  BTN_DEB_RST    = 16'd30;
  localparam logic [DEB_W-1:0]  LONG_PRESS_RST = 16'd3000;
  localparam logic [IDLE_W-1:0] IDLE_TO_RST    = 31'd60000;

  typedef struct packed {
    logic [DEB_W-1:0]  touch_debounce_ms;
    logic [DEB_W-1:0]  button_debounce_ms;
    logic [DEB_W-1:0]  long_press_ms;
    logic [IDLE_W-1:0] idle_timeout_ms;
  } tbeq_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic                      touch_valid;
    logic                      touch_pressed;
    logic signed [COORD_W-1:0] touch_x;
    logic signed [COORD_W-1:0] touch_y;
    logic [NUM_BUTTONS-1:0]    btn_level;
    logic                      arm_suppress;
    logic [TIME_W-1:0]         suppress_until;
  } tbeq_item_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]      mask;
    logic [KIND_W-1:0]         touch_kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [TIME_W-1:0]         time_ms;
  } tbeq_bundle_t;

endpackage

### rtl/tbeq_core.sv
// ----------------------------------------------------------------------------
// tbeq_core
// Input register, qualifier state and the single-pass event logic.
// ----------------------------------------------------------------------------
module tbeq_core import tbeq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tbeq_cfg_t    cfg,
  input  logic         in_vld,
  output logic         in_rdy,
  input  tbeq_item_t   in_item,
  input  logic         bnd_rdy,
  output logic         bnd_ld,
  output tbeq_bundle_t bnd
);

  logic       inq_vld_r, inq_vld_nxt;
  tbeq_item_t inq_r;
  logic       adv;

  logic                      held_r, held_nxt;
  logic signed [COORD_W-1:0] hx_r, hx_nxt, hy_r, hy_nxt;
  logic [TIME_W-1:0]         rel_r, rel_nxt;
  logic [TIME_W-1:0]         sd_r, sd_nxt;
  logic [NUM_BUTTONS-1:0]    bst_r, bst_nxt;
  logic [TIME_W-1:0]         bct_r [NUM_BUTTONS];
  logic [TIME_W-1:0]         bct_nxt [NUM_BUTTONS];
  logic [TIME_W-1:0]         mid_r, mid_nxt;
  logic [TIME_W-1:0]         act_r, act_nxt;
  logic                      idle_r, idle_nxt;

  logic [TIME_W-1:0]      now, sd, sdiff, wdiff, mdiff, idiff, act_eff;
  logic [TIME_W-1:0]      bdiff [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] chg;
  logic                   sup, tact, win;
  logic                   t_down, t_move, t_up, any_act, sent_eff;
  logic                   ev_back, ev_nav_up, ev_nav_dn, ev_idle;

  assign in_rdy = !inq_vld_r || bnd_rdy;
  assign adv    = inq_vld_r && bnd_rdy;
  assign now    = inq_r.now_ms;

  always_comb begin
    inq_vld_nxt = inq_vld_r;
    if (in_vld && in_rdy) begin
      inq_vld_nxt = 1'b1;
    end else if (adv) begin
      inq_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    sd    = inq_r.arm_suppress ? inq_r.suppress_until : sd_r;
    sdiff = now - sd;
    sup   = (sd != '0) && sdiff[TIME_W-1];
    tact  = inq_r.touch_valid && !sup;
    wdiff = now - rel_r;
    win   = wdiff < {{(TIME_W-DEB_W){1'b0}}, cfg.touch_debounce_ms};

    t_down = tact && inq_r.touch_pressed && !held_r && !win;
    t_move = tact && inq_r.touch_pressed && held_r &&
             ((inq_r.touch_x != hx_r) || (inq_r.touch_y != hy_r));
    t_up   = tact && !inq_r.touch_pressed && held_r;

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      bdiff[i] = now - bct_r[i];
      chg[i]   = (inq_r.btn_level[i] != bst_r[i]) &&
                 (bdiff[i] >= {{(TIME_W-DEB_W){1'b0}}, cfg.button_debounce_ms});
    end

    mdiff     = now - mid_r;
    ev_back   = chg[BTN_MID] && !inq_r.btn_level[BTN_MID] &&
                (mdiff < {{(TIME_W-DEB_W){1'b0}}, cfg.long_press_ms});
    ev_nav_up = chg[BTN_NAV_UP] && inq_r.btn_level[BTN_NAV_UP];
    ev_nav_dn = chg[BTN_NAV_DN] && inq_r.btn_level[BTN_NAV_DN];

    any_act  = t_down || t_move || t_up || (|chg);
    act_eff  = any_act ? now : act_r;
    sent_eff = any_act ? 1'b0 : idle_r;
    idiff    = now - act_eff;
    ev_idle  = !sent_eff && !idiff[TIME_W-1] &&
               (idiff[IDLE_W-1:0] >= cfg.idle_timeout_ms);

    held_nxt = held_r;
    if (inq_r.touch_valid && sup) begin
      held_nxt = 1'b0;
    end else if (t_down) begin
      held_nxt = 1'b1;
    end else if (t_up) begin
      held_nxt = 1'b0;
    end
    hx_nxt  = (t_down || t_move) ? inq_r.touch_x : hx_r;
    hy_nxt  = (t_down || t_move) ? inq_r.touch_y : hy_r;
    rel_nxt = t_up ? now : rel_r;
    sd_nxt  = tact ? '0 : sd;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      bst_nxt[i] = chg[i] ? inq_r.btn_level[i] : bst_r[i];
      bct_nxt[i] = chg[i] ? now : bct_r[i];
    end
    mid_nxt  = (chg[BTN_MID] && inq_r.btn_level[BTN_MID]) ? now : mid_r;
    act_nxt  = act_eff;
    idle_nxt = ev_idle || sent_eff;

    bnd.mask = '0;
    bnd.mask[SLOT_TOUCH]  = t_down || t_move || t_up;
    bnd.mask[SLOT_NAV_UP] = ev_nav_up;
    bnd.mask[SLOT_BACK]   = ev_back;
    bnd.mask[SLOT_NAV_DN] = ev_nav_dn;
    bnd.mask[SLOT_IDLE]   = ev_idle;
    priority if (t_down) begin
      bnd.touch_kind = EV_TOUCH_DOWN;
    end else if (t_move) begin
      bnd.touch_kind = EV_TOUCH_MOVE;
    end else begin
      bnd.touch_kind = EV_TOUCH_UP;
    end
    bnd.x       = t_up ? hx_r : inq_r.touch_x;
    bnd.y       = t_up ? hy_r : inq_r.touch_y;
    bnd.time_ms = now;
  end

  assign bnd_ld = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_vld_r <= 1'b0;
    end else begin
      inq_vld_r <= inq_vld_nxt;
    end
    if (in_vld && in_rdy) begin
      inq_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      hx_r   <= '0;
      hy_r   <= '0;
      rel_r  <= '0;
      sd_r   <= '0;
      bst_r  <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        bct_r[i] <= '0;
      end
      mid_r  <= '0;
      act_r  <= '0;
      idle_r <= 1'b0;
    end else if (adv) begin
      held_r <= held_nxt;
      hx_r   <= hx_nxt;
      hy_r   <= hy_nxt;
      rel_r  <= rel_nxt;
      sd_r   <= sd_nxt;
      bst_r  <= bst_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        bct_r[i] <= bct_nxt[i];
      end
      mid_r  <= mid_nxt;
      act_r  <= act_nxt;
      idle_r <= idle_nxt;
    end
  end

  a_idle_marks_sent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ev_idle |=> idle_r)
    else $error("idle event without idle_sent");

  a_act_time: assert property (@(posedge clk) disable iff (!rst_n)
    adv && any_act |=> act_r == $past(now))
    else $error("activity time not taken from item");

  a_up_releases: assert property (@(posedge clk) disable iff (!rst_n)
    adv && t_up |=> !held_r && rel_r == $past(now))
    else $error("touch up left contact held");

endmodule

### rtl/tbeq_ser.sv
// ----------------------------------------------------------------------------
// tbeq_ser
// Event register: holds the events of one item and emits them in order.
// ----------------------------------------------------------------------------
module tbeq_ser import tbeq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  bnd_ld,
  input  tbeq_bundle_t          bnd,
  output logic                  bnd_rdy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  logic [NUM_SLOTS-1:0]      mask_r, mask_nxt, cur, rest;
  logic [KIND_W-1:0]         tkind_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic [TIME_W-1:0]         time_r;
  logic [KIND_W-1:0]         kind;
  logic [BTN_W-1:0]          btn;
  logic signed [COORD_W-1:0] ex, ey;

  assign cur        = mask_r & (~mask_r + NUM_SLOTS'(1));
  assign rest       = mask_r & ~cur;
  assign out_tvalid = |mask_r;
  assign out_tlast  = (rest == '0);
  assign bnd_rdy    = (mask_r == '0) || (out_tready && out_tlast);

  always_comb begin
    kind = EV_IDLE;
    btn  = '0;
    ex   = '0;
    ey   = '0;
    priority if (cur[SLOT_TOUCH]) begin
      kind = tkind_r;
      ex   = x_r;
      ey   = y_r;
    end else if (cur[SLOT_NAV_UP]) begin
      kind = EV_NAV_UP;
      btn  = BTN_W'(BTN_NAV_UP);
    end else if (cur[SLOT_BACK]) begin
      kind = EV_BACK;
    end else if (cur[SLOT_NAV_DN]) begin
      kind = EV_NAV_DOWN;
      btn  = BTN_W'(BTN_NAV_DN);
    end else begin
      kind = EV_IDLE;
    end
  end

  // tdata: event_x, event_y, button_index, event_time_ms, zero fill
  assign out_tdata = {6'b0, time_r, btn, ey, ex};
  assign out_tuser = kind;

  always_comb begin
    mask_nxt = mask_r;
    if (bnd_ld) begin
      mask_nxt = bnd.mask;
    end else if (out_tvalid && out_tready) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
    if (bnd_ld) begin
      tkind_r <= bnd.touch_kind;
      x_r     <= bnd.x;
      y_r     <= bnd.y;
      time_r  <= bnd.time_ms;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_ld && out_tvalid |-> out_tready && out_tlast)
    else $error("event register overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_ld && (bnd.mask != '0) |=> out_tvalid && time_r == $past(bnd.time_ms))
    else $error("loaded events not presented");

endmodule

### rtl/touch_button_event_qualifier_unit.sv
// ----------------------------------------------------------------------------
// touch_button_event_qualifier_unit
// Turns ticks of raw touch and button input into qualified events.
// ----------------------------------------------------------------------------
// One tick enters on the in_ stream. It is held in an input register, then
// evaluated combinationally against the touch, button, suppression and idle
// state; the events it causes (up to five) land in an event register and
// leave on the out_ stream one per cycle while out_tready is high, in the
// order touch, nav up, back, nav down, idle, with tlast on the final event
// of the tick. A tick with no event produces nothing on the output.
// A tick passes through the input register and then the event register
// before its first event appears. With out_tready held high, ticks with at
// most one event each are taken one per cycle.
// A new tick is accepted while the previous events are still being drained.
// When the receiver stalls, the event register holds and the input register
// fills, after which in_tready drops.
// Reset (synchronous, rst_n low) clears all state and loads the register
// defaults: 150, 30, 3000, 60000 ms. Write cfg_ only while idle.
// ----------------------------------------------------------------------------
module touch_button_event_qualifier_unit import tbeq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_ms, touch_valid, touch_pressed, touch_x, touch_y, btn_up_level,
  // btn_mid_level, btn_down_level, arm_suppress, suppress_until, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // event_x, event_y, button_index, event_time_ms, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // event_kind
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [ADDR_W-1:0]     cfg_addr,
  input  logic [IDLE_W-1:0]     cfg_wdata
);

  tbeq_cfg_t    cfg_r, cfg_nxt;
  tbeq_item_t   item;
  tbeq_bundle_t bnd;
  logic         bnd_ld, bnd_rdy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_TOUCH_DEB:  cfg_nxt.touch_debounce_ms  = cfg_wdata[DEB_W-1:0];
        REG_BTN_DEB:    cfg_nxt.button_debounce_ms = cfg_wdata[DEB_W-1:0];
        REG_LONG_PRESS: cfg_nxt.long_press_ms      = cfg_wdata[DEB_W-1:0];
        REG_IDLE_TO:    cfg_nxt.idle_timeout_ms    = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_debounce_ms  <= TOUCH_DEB_RST;
      cfg_r.button_debounce_ms <= BTN_DEB_RST;
      cfg_r.long_press_ms      <= LONG_PRESS_RST;
      cfg_r.idle_timeout_ms    <= IDLE_TO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    item.now_ms         = in_tdata[31:0];
    item.touch_valid    = in_tdata[32];
    item.touch_pressed  = in_tdata[33];
    item.touch_x        = in_tdata[49:34];
    item.touch_y        = in_tdata[65:50];
    item.btn_level      = in_tdata[68:66];
    item.arm_suppress   = in_tdata[69];
    item.suppress_until = in_tdata[101:70];
  end

  tbeq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vld  (in_tvalid),
    .in_rdy  (in_tready),
    .in_item (item),
    .bnd_rdy (bnd_rdy),
    .bnd_ld  (bnd_ld),
    .bnd     (bnd)
  );

  tbeq_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .bnd_ld     (bnd_ld),
    .bnd        (bnd),
    .bnd_rdy    (bnd_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
